[hdl/vtms_pkg.sv]
// Shared types and constants for the version tag maximum scanner.
package vtms_pkg;

    localparam int TagLen = 6;

    // Bytes of the tag prefix, in stream order.
    localparam logic [7:0] TagBytes [TagLen] = '{8'h47, 8'h4C, 8'h49, 8'h42, 8'h43, 8'h5F};

    localparam logic [7:0] ByteZero = 8'h00;
    localparam logic [7:0] ByteDot  = 8'h2E;
    localparam logic [7:0] DigitLo  = 8'h30;
    localparam logic [7:0] DigitHi  = 8'h39;

    // Scan phases, one-hot.
    typedef enum logic [5:0] {
        PH_PREFIX    = 6'b000001,
        PH_MAJ_FIRST = 6'b000010,
        PH_MAJ       = 6'b000100,
        PH_MIN_FIRST = 6'b001000,
        PH_MIN       = 6'b010000,
        PH_SKIP      = 6'b100000
    } phase_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic              last;
        logic              zero;
        logic              dot;
        logic              digit_ok;
        logic [3:0]        digit;
        logic [TagLen-1:0] tag_hit;
    } byte_class_t;

endpackage

[hdl/vtms_if.sv]
// Channel interfaces for the scanner input bytes and the scan result.
interface vtms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface vtms_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] best_major;
    logic [31:0] best_minor;

    modport source (output valid, output found, output best_major, output best_minor,
                    input ready);
    modport sink (input valid, input found, input best_major, input best_minor,
                  output ready);
endinterface

[hdl/version_tag_max_scanner.sv]
// Top level of the version tag maximum scanner.
//
//   Channel   Dir   Payload                            Transfer rule
//   scan      in    data_byte[7:0], last               valid && ready at rising clk
//   result    out   found, best_major[31:0], best_minor[31:0]  valid && ready at rising clk
//
// One byte can be taken every cycle; the back end retires one queued byte per cycle.
// A last byte passes the front register and the queue, then the result register is loaded.
// rst_n clears the queue, the scan state and the valid flag of the result register at once.
// A stalled result holds the back end; the queue of QUEUE_DEPTH entries and the
// front register then absorb input bytes before scan.ready falls.
module version_tag_max_scanner
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    vtms_in_if.sink    scan,
    vtms_out_if.source result
);

    logic                  push_valid;
    logic                  push_ready;
    vtms_pkg::byte_class_t push_entry;
    logic                  pop_valid;
    logic                  pop_ready;
    vtms_pkg::byte_class_t pop_entry;

    vtms_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan       (scan),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    vtms_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    vtms_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .result    (result)
    );

endmodule

[hdl/vtms_front.sv]
// Front stage: accepts input bytes, classifies them and registers the class.
module vtms_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    vtms_in_if.sink               scan,
    output logic                  push_valid,
    input  logic                  push_ready,
    output vtms_pkg::byte_class_t push_entry
);

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    vtms_pkg::byte_class_t stage_entry_reg;
    vtms_pkg::byte_class_t stage_entry_next;
    logic [7:0]            digit_val;

    assign scan.ready = !stage_valid_reg || push_ready;
    assign push_valid = stage_valid_reg;
    assign push_entry = stage_entry_reg;

    assign digit_val = scan.data_byte - vtms_pkg::DigitLo;

    always_comb
    begin
        stage_entry_next.last     = scan.last;
        stage_entry_next.zero     = (scan.data_byte == vtms_pkg::ByteZero);
        stage_entry_next.dot      = (scan.data_byte == vtms_pkg::ByteDot);
        stage_entry_next.digit_ok = (scan.data_byte >= vtms_pkg::DigitLo) &&
                                    (scan.data_byte <= vtms_pkg::DigitHi);
        stage_entry_next.digit    = digit_val[3:0];
        for (int i = 0; i < vtms_pkg::TagLen; i++)
        begin
            stage_entry_next.tag_hit[i] = (scan.data_byte == vtms_pkg::TagBytes[i]);
        end
    end

    assign stage_valid_next = scan.ready ? scan.valid : stage_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            stage_entry_reg <= stage_entry_next;
        end
    end

endmodule

[hdl/vtms_queue.sv]
// Small queue of classified bytes between the front and the back.
module vtms_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  vtms_pkg::byte_class_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output vtms_pkg::byte_class_t pop_entry
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    vtms_pkg::byte_class_t mem [DEPTH];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push_fire;
    logic            pop_fire;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[hdl/vtms_back.sv]
// Back stage: tag recognizer, number accumulation, maximum tracking and result register.
module vtms_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  vtms_pkg::byte_class_t pop_entry,
    vtms_out_if.source            result
);

    vtms_pkg::phase_t phase_reg;
    vtms_pkg::phase_t phase_next;
    logic [2:0]       pos_reg;
    logic [2:0]       pos_next;
    logic [31:0]      maj_reg;
    logic [31:0]      maj_next;
    logic [31:0]      min_reg;
    logic [31:0]      min_next;
    logic             found_reg;
    logic             found_next;
    logic [31:0]      gmaj_reg;
    logic [31:0]      gmaj_next;
    logic [31:0]      gmin_reg;
    logic [31:0]      gmin_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_found_reg;
    logic [31:0]      out_major_reg;
    logic [31:0]      out_minor_reg;

    logic             pop_fire;
    logic             prefix_hit;
    logic [31:0]      acc_sel;
    logic [35:0]      acc_ext;
    logic [35:0]      acc_sum;
    logic             acc_ovf;
    logic             beats_kept;

    assign pop_ready = !out_valid_reg || result.ready;
    assign pop_fire  = pop_valid && pop_ready;

    assign result.valid      = out_valid_reg;
    assign result.found      = out_found_reg;
    assign result.best_major = out_major_reg;
    assign result.best_minor = out_minor_reg;

    assign prefix_hit = (pos_reg < 3'(vtms_pkg::TagLen)) && pop_entry.tag_hit[pos_reg];

    // One shared digit-append unit: acc * 10 + digit, with a 32-bit overflow check.
    assign acc_sel = (phase_reg == vtms_pkg::PH_MAJ) ? maj_reg : min_reg;
    assign acc_ext = {4'b0000, acc_sel};
    assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {32'b0, pop_entry.digit};
    assign acc_ovf = (acc_sum[35:32] != 4'b0000);

    assign beats_kept = !found_reg || (maj_reg > gmaj_reg) ||
                        ((maj_reg == gmaj_reg) && (min_reg > gmin_reg));

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        maj_next       = maj_reg;
        min_next       = min_reg;
        found_next     = found_reg;
        gmaj_next      = gmaj_reg;
        gmin_next      = gmin_reg;
        out_valid_next = out_valid_reg && !result.ready;

        if (pop_fire)
        begin
            unique case (phase_reg)
                vtms_pkg::PH_PREFIX:
                begin
                    if (prefix_hit)
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg == 3'(vtms_pkg::TagLen - 1))
                        begin
                            phase_next = vtms_pkg::PH_MAJ_FIRST;
                            pos_next   = 3'd0;
                            maj_next   = '0;
                            min_next   = '0;
                        end
                    end
                    else
                    begin
                        phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                        pos_next   = 3'd0;
                    end
                end
                vtms_pkg::PH_MAJ_FIRST:
                begin
                    if (pop_entry.digit_ok)
                    begin
                        maj_next   = {28'b0, pop_entry.digit};
                        phase_next = vtms_pkg::PH_MAJ;
                    end
                    else
                    begin
                        phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                    end
                end
                vtms_pkg::PH_MAJ:
                begin
                    if (pop_entry.digit_ok)
                    begin
                        if (acc_ovf)
                        begin
                            phase_next = vtms_pkg::PH_SKIP;
                        end
                        else
                        begin
                            maj_next = acc_sum[31:0];
                        end
                    end
                    else if (pop_entry.dot)
                    begin
                        phase_next = vtms_pkg::PH_MIN_FIRST;
                    end
                    else
                    begin
                        phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                    end
                end
                vtms_pkg::PH_MIN_FIRST:
                begin
                    if (pop_entry.digit_ok)
                    begin
                        min_next   = {28'b0, pop_entry.digit};
                        phase_next = vtms_pkg::PH_MIN;
                    end
                    else
                    begin
                        phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                    end
                end
                vtms_pkg::PH_MIN:
                begin
                    if (pop_entry.digit_ok)
                    begin
                        if (acc_ovf)
                        begin
                            phase_next = vtms_pkg::PH_SKIP;
                        end
                        else
                        begin
                            min_next = acc_sum[31:0];
                        end
                    end
                    else
                    begin
                        // A zero byte closes a complete tag.
                        if (pop_entry.zero && beats_kept)
                        begin
                            gmaj_next  = maj_reg;
                            gmin_next  = min_reg;
                            found_next = 1'b1;
                        end
                        phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                    end
                end
                default:
                begin
                    phase_next = pop_entry.zero ? vtms_pkg::PH_PREFIX : vtms_pkg::PH_SKIP;
                    pos_next   = 3'd0;
                end
            endcase

            if (pop_entry.last)
            begin
                out_valid_next = 1'b1;
                phase_next     = vtms_pkg::PH_PREFIX;
                pos_next       = 3'd0;
                maj_next       = '0;
                min_next       = '0;
                found_next     = 1'b0;
                gmaj_next      = '0;
                gmin_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= vtms_pkg::PH_PREFIX;
            pos_reg       <= 3'd0;
            maj_reg       <= '0;
            min_reg       <= '0;
            found_reg     <= 1'b0;
            gmaj_reg      <= '0;
            gmin_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            maj_reg       <= maj_next;
            min_reg       <= min_next;
            found_reg     <= found_next;
            gmaj_reg      <= gmaj_next;
            gmin_reg      <= gmin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result sees the maximum including a tag closed by the last byte itself.
    always_ff @(posedge clk)
    begin
        if (pop_fire && pop_entry.last)
        begin
            if (phase_reg == vtms_pkg::PH_MIN && pop_entry.zero && beats_kept)
            begin
                out_found_reg <= 1'b1;
                out_major_reg <= maj_reg;
                out_minor_reg <= min_reg;
            end
            else
            begin
                out_found_reg <= found_reg;
                out_major_reg <= found_reg ? gmaj_reg : '0;
                out_minor_reg <= found_reg ? gmin_reg : '0;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire && pop_entry.last |=> !found_reg && phase_reg == vtms_pkg::PH_PREFIX)
        else $error("scan state not cleared after the last byte");

    a_pos_only_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 3'd0 |-> phase_reg == vtms_pkg::PH_PREFIX)
        else $error("prefix position held outside prefix matching");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_found_reg |-> out_major_reg == '0 && out_minor_reg == '0)
        else $error("result without a tag carries nonzero numbers");

    a_no_pop_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !pop_fire)
        else $error("byte consumed while a result is stalled");
`endif

endmodule

[test/version_tag_max_scanner_tb.sv]
// Self-checking testbench for the version tag maximum scanner, driven with directed and random byte images.
module version_tag_max_scanner_tb;

    typedef struct packed {
        logic        found;
        logic [31:0] major;
        logic [31:0] minor;
    } scan_result_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    typedef enum int {
        SEG_TAG,
        SEG_BROKEN,
        SEG_NOISE,
        SEG_EMBEDDED,
        SEG_EMPTY,
        SEG_NO_MINOR,
        SEG_PARTIAL
    } segment_kind_t;

    localparam int CycleLimit      = 400000;
    localparam int DrainCycles     = 20;
    localparam int RandomBytes     = 1000;
    localparam int RandomImagesMin = 28;
    localparam int ReportLimit     = 10;
    localparam int LongHold        = 400;

    logic clk = 1'b0;
    logic rst_n;

    vtms_in_if  scan_ch ();
    vtms_out_if result_ch ();

    version_tag_max_scanner dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_ch),
        .result (result_ch)
    );

    // Shadow copy of the scan state.
    vtms_pkg::phase_t scan_phase;
    int               prefix_pos;
    logic [31:0]      major_acc;
    logic [31:0]      minor_acc;
    logic             have_tag;
    logic [31:0]      top_major;
    logic [31:0]      top_minor;

    scan_result_t pending_results[$];
    logic [7:0]   image[$];

    int       mismatches   = 0;
    int       cycle_count  = 0;
    int       hold_request = 0;
    int       hold_left    = 0;
    int       burst_left   = 0;
    int       rx_mode_left = 0;
    rx_mode_t rx_mode      = RX_OPEN;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_scan();
        scan_phase = vtms_pkg::PH_PREFIX;
        prefix_pos = 0;
        major_acc  = '0;
        minor_acc  = '0;
        have_tag   = 1'b0;
        top_major  = '0;
        top_minor  = '0;
    endfunction

    // A zero byte lets a new candidate start on the next byte; anything else skips the string.
    function automatic void drop_candidate(logic [7:0] b);
        if (b == vtms_pkg::ByteZero)
        begin
            scan_phase = vtms_pkg::PH_PREFIX;
        end
        else
        begin
            scan_phase = vtms_pkg::PH_SKIP;
        end
        prefix_pos = 0;
    endfunction

    function automatic logic [35:0] shifted_in(logic [31:0] acc, logic [7:0] b);
        return {4'd0, acc} * 36'd10 + 36'(b - vtms_pkg::DigitLo);
    endfunction

    function automatic void absorb_byte(logic [7:0] b, logic is_last);
        logic         is_num;
        logic [35:0]  grown;
        scan_result_t r;
        is_num = (b >= vtms_pkg::DigitLo) && (b <= vtms_pkg::DigitHi);
        case (scan_phase)
            vtms_pkg::PH_PREFIX:
            begin
                if (prefix_pos < vtms_pkg::TagLen && b == vtms_pkg::TagBytes[prefix_pos])
                begin
                    prefix_pos++;
                    if (prefix_pos == vtms_pkg::TagLen)
                    begin
                        scan_phase = vtms_pkg::PH_MAJ_FIRST;
                        major_acc  = '0;
                        minor_acc  = '0;
                    end
                end
                else
                begin
                    drop_candidate(b);
                end
            end
            vtms_pkg::PH_MAJ_FIRST:
            begin
                if (is_num)
                begin
                    major_acc  = 32'(b - vtms_pkg::DigitLo);
                    scan_phase = vtms_pkg::PH_MAJ;
                end
                else
                begin
                    drop_candidate(b);
                end
            end
            vtms_pkg::PH_MAJ:
            begin
                if (is_num)
                begin
                    grown = shifted_in(major_acc, b);
                    if (grown > 36'hFFFF_FFFF)
                    begin
                        drop_candidate(b);
                    end
                    else
                    begin
                        major_acc = grown[31:0];
                    end
                end
                else if (b == vtms_pkg::ByteDot)
                begin
                    scan_phase = vtms_pkg::PH_MIN_FIRST;
                end
                else
                begin
                    drop_candidate(b);
                end
            end
            vtms_pkg::PH_MIN_FIRST:
            begin
                if (is_num)
                begin
                    minor_acc  = 32'(b - vtms_pkg::DigitLo);
                    scan_phase = vtms_pkg::PH_MIN;
                end
                else
                begin
                    drop_candidate(b);
                end
            end
            vtms_pkg::PH_MIN:
            begin
                if (is_num)
                begin
                    grown = shifted_in(minor_acc, b);
                    if (grown > 36'hFFFF_FFFF)
                    begin
                        drop_candidate(b);
                    end
                    else
                    begin
                        minor_acc = grown[31:0];
                    end
                end
                else
                begin
                    // Only a zero closes a tag; an equal pair leaves the kept one alone.
                    if (b == vtms_pkg::ByteZero && (!have_tag || major_acc > top_major ||
                        (major_acc == top_major && minor_acc > top_minor)))
                    begin
                        top_major = major_acc;
                        top_minor = minor_acc;
                        have_tag  = 1'b1;
                    end
                    drop_candidate(b);
                end
            end
            default:
            begin
                drop_candidate(b);
            end
        endcase

        if (is_last)
        begin
            r.found = have_tag;
            r.major = top_major;
            r.minor = top_minor;
            pending_results.push_back(r);
            clear_scan();
        end
    endfunction

    // The sender offers bytes in bursts; a gap is placed before the first byte of each burst.
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                burst_left = $urandom_range(30, 120);
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
            end
        end
        burst_left--;
        scan_ch.valid     <= 1'b1;
        scan_ch.data_byte <= b;
        scan_ch.last      <= is_last;
        @(posedge clk);
        while (scan_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        absorb_byte(b, is_last);
    endtask

    task automatic send_image();
        for (int i = 0; i < image.size(); i++)
        begin
            send_byte(image[i], i == image.size() - 1);
        end
        image.delete();
    endtask

    task automatic wait_drained();
        scan_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic push_prefix(input int count);
        for (int i = 0; i < count; i++)
        begin
            image.push_back(vtms_pkg::TagBytes[i]);
        end
    endtask

    task automatic push_decimal(input longint unsigned v, input int lead_zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (lead_zeros) image.push_back(vtms_pkg::DigitLo);
        for (int i = 0; i < s.len(); i++)
        begin
            image.push_back(s[i]);
        end
    endtask

    task automatic push_tag(input longint unsigned maj, input longint unsigned min,
                            input int lead_zeros);
        push_prefix(vtms_pkg::TagLen);
        push_decimal(maj, lead_zeros);
        image.push_back(vtms_pkg::ByteDot);
        push_decimal(min, lead_zeros);
        image.push_back(vtms_pkg::ByteZero);
    endtask

    // Small values dominate so that equal and near-equal pairs meet often.
    function automatic longint unsigned pick_number();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 3);
            4, 5:       return $urandom_range(0, 999);
            6:          return $urandom;
            7:          return 64'hFFFF_FFFF - $urandom_range(0, 2);
            8:          return 64'h1_0000_0000 + $urandom_range(0, 2);
            default:    return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int pick_padding();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(1, 3);
        end
        return 0;
    endfunction

    task automatic build_random_image();
        int            segments;
        int            pick;
        int            start;
        int            spot;
        segment_kind_t kind;
        segments = $urandom_range(1, 4);
        for (int s = 0; s < segments; s++)
        begin
            pick = $urandom_range(0, 9);
            kind = (pick < 4) ? SEG_TAG : segment_kind_t'(pick - 3);
            case (kind)
                SEG_TAG:
                begin
                    push_tag(pick_number(), pick_number(), pick_padding());
                end
                SEG_BROKEN:
                begin
                    start = image.size();
                    push_tag(pick_number(), pick_number(), pick_padding());
                    spot = $urandom_range(start, image.size() - 2);
                    image[spot] = 8'($urandom_range(0, 255));
                end
                SEG_NOISE:
                begin
                    repeat ($urandom_range(1, 8)) image.push_back(8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 1) == 1)
                    begin
                        image.push_back(vtms_pkg::ByteZero);
                    end
                end
                SEG_EMBEDDED:
                begin
                    // A tag that does not start a string must be skipped.
                    repeat ($urandom_range(1, 3)) image.push_back(8'($urandom_range(1, 255)));
                    push_tag(pick_number(), pick_number(), 0);
                end
                SEG_EMPTY:
                begin
                    image.push_back(vtms_pkg::ByteZero);
                end
                SEG_NO_MINOR:
                begin
                    push_prefix(vtms_pkg::TagLen);
                    push_decimal(pick_number(), 0);
                    if ($urandom_range(0, 1) == 1)
                    begin
                        image.push_back(vtms_pkg::ByteDot);
                    end
                    image.push_back(vtms_pkg::ByteZero);
                end
                default:
                begin
                    push_prefix($urandom_range(1, vtms_pkg::TagLen - 1));
                    image.push_back(vtms_pkg::ByteZero);
                end
            endcase
        end
        // Sometimes the image ends inside a tag that is never closed.
        if ($urandom_range(0, 3) == 0)
        begin
            push_tag(pick_number(), pick_number(), 0);
            image.pop_back();
        end
    endtask

    task automatic test_single_bytes();
        image.push_back(vtms_pkg::ByteZero);
        send_image();
        image.push_back(8'hFF);
        send_image();
        wait_drained();
    endtask

    task automatic test_number_extremes();
        // Largest pair, closed by the last byte of the image.
        push_tag(0, 0, 0);
        push_tag(64'hFFFF_FFFF, 64'hFFFF_FFFF, 0);
        send_image();
        // Numbers one past the range are rejected; leading zeros are harmless.
        push_tag(64'h1_0000_0000, 1, 0);
        push_tag(1, 64'h1_0000_0000, 0);
        push_tag(2, 0, 2);
        send_image();
        wait_drained();
    endtask

    task automatic test_tag_rules();
        image.push_back(8'h41);
        push_tag(9, 9, 0);
        push_tag(3, 7, 0);
        push_tag(3, 7, 0);
        push_tag(3, 2, 0);
        push_prefix(vtms_pkg::TagLen);
        push_decimal(5, 0);
        image.push_back(vtms_pkg::ByteZero);
        push_tag(8, 8, 0);
        image.pop_back();
        send_image();
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_request = LongHold;
        push_tag(7, 3, 0);
        send_image();
        repeat (3)
        begin
            build_random_image();
            send_image();
        end
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (4)
        begin
            build_random_image();
            send_image();
            wait_drained();
        end
    endtask

    task automatic test_random_images();
        int bytes_sent;
        int images_sent;
        bytes_sent  = 0;
        images_sent = 0;
        while (bytes_sent < RandomBytes || images_sent < RandomImagesMin)
        begin
            build_random_image();
            bytes_sent += image.size();
            images_sent++;
            send_image();
        end
        wait_drained();
    endtask

    // The receiver switches among stall patterns and honors long holds on request.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:     result_ch.ready <= 1'b1;
                RX_COIN:     result_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   result_ch.ready <= ($urandom_range(0, 3) == 0);
                default:     result_ch.ready <= ((cycle_count % 4) != 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        scan_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < ReportLimit)
                begin
                    $display("unexpected result transfer: found=%0b major=%0d minor=%0d",
                             result_ch.found, result_ch.best_major, result_ch.best_minor);
                end
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.found !== want.found || result_ch.best_major !== want.major ||
                    result_ch.best_minor !== want.minor)
                begin
                    if (mismatches < ReportLimit)
                    begin
                        $display({"result differs: expected found=%0b major=%0d minor=%0d,",
                                  " got found=%0b major=%0d minor=%0d"},
                                 want.found, want.major, want.minor,
                                 result_ch.found, result_ch.best_major, result_ch.best_minor);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("version_tag_max_scanner: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        scan_ch.valid     = 1'b0;
        scan_ch.data_byte = '0;
        scan_ch.last      = 1'b0;
        result_ch.ready   = 1'b0;
        clear_scan();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_bytes();
        test_number_extremes();
        test_tag_rules();
        test_backpressure();
        test_drain_pause();
        test_random_images();

        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("version_tag_max_scanner: match");
        end
        else
        begin
            $display("version_tag_max_scanner: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
hdl/vtms_pkg.sv
hdl/vtms_if.sv
hdl/vtms_front.sv
hdl/vtms_queue.sv
hdl/vtms_back.sv
hdl/version_tag_max_scanner.sv
test/version_tag_max_scanner_tb.sv
